[design/svpwm_pkg.sv]
// Shared widths, constants and types of the space vector PWM duty generator.
package svpwm_pkg;

  // Input, output and configuration field widths.
  localparam int unsigned InW     = 16;
  localparam int unsigned CmpW    = 17;
  localparam int unsigned DutyW   = 18;
  localparam int unsigned SecW    = 3;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgW    = 16;

  // Internal datapath widths.
  localparam int unsigned ProdW = 2 * InW;       // one 16x16 product
  localparam int unsigned XyW   = ProdW + 1;     // stator frame components
  localparam int unsigned CrsW  = 44;            // scaled components and cross products
  localparam int unsigned MagW  = 44;            // dividend magnitude, twice a cross product
  localparam int unsigned DenW  = 26;            // 866 times the bus voltage
  localparam int unsigned QuoW  = 35;            // quotient bits, one divider stage each
  localparam int unsigned RemW  = DenW + 1;
  localparam int unsigned DW    = 40;            // dwell times and raw duties

  // Fixed coefficients of the hexagon reference vectors, in thousandths.
  localparam logic signed [CrsW-1:0] Cos30Milli = CrsW'(866);
  localparam logic signed [CrsW-1:0] HalfMilli  = CrsW'(500);
  localparam logic signed [CrsW-1:0] OneMilli   = CrsW'(1000);
  localparam logic [DenW-1:0]        DenCos30   = DenW'(866);

  // Q.16 one.
  localparam logic signed [DW-1:0] OneQ16 = DW'(65536);

  // Configuration register indexes and reset values.
  localparam logic [CfgIdxW-1:0] CfgDcBus  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgPeriod = CfgIdxW'(1);
  localparam logic [CfgW-1:0]    DcBusRst  = CfgW'(6144);
  localparam logic [CfgW-1:0]    PeriodRst = CfgW'(4200);

  // Sector numbers.
  localparam logic [SecW-1:0] Sector0 = SecW'(0);
  localparam logic [SecW-1:0] Sector1 = SecW'(1);
  localparam logic [SecW-1:0] Sector2 = SecW'(2);
  localparam logic [SecW-1:0] Sector3 = SecW'(3);
  localparam logic [SecW-1:0] Sector4 = SecW'(4);
  localparam logic [SecW-1:0] Sector5 = SecW'(5);

  // Side information that rides along with an item through the divider.
  typedef struct packed {
    logic [SecW-1:0] sector;
    logic            neg1;
    logic            neg2;
  } div_side_t;

  // Clamp a raw duty to [-1, 1] in Q.16.
  function automatic logic signed [DutyW-1:0] clamp_duty(input logic signed [DW-1:0] d);
    logic signed [DutyW-1:0] r;
    if (d < -OneQ16) begin
      r = DutyW'(-OneQ16);
    end else if (d > OneQ16) begin
      r = DutyW'(OneQ16);
    end else begin
      r = DutyW'(d);
    end
    return r;
  endfunction

endpackage

[design/svpwm_div.sv]
// Pipelined restoring divider: two dividends over one divisor, one quotient bit per stage.
module svpwm_div (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       en_i,
  input  logic                                       valid_i,
  input  logic [1:0][svpwm_pkg::MagW-1:0]            mag_i,
  input  svpwm_pkg::div_side_t                       side_i,
  input  logic [svpwm_pkg::DenW-1:0]                 den_i,
  output logic                                       valid_o,
  output logic [1:0][svpwm_pkg::QuoW-1:0]            quo_o,
  output svpwm_pkg::div_side_t                       side_o
);

  localparam int unsigned N = svpwm_pkg::QuoW;

  // Stage registers; entry k holds the result of stage k.
  logic [N-1:0]                          vld_q;
  logic [1:0][svpwm_pkg::RemW-1:0]       rem_q [N];
  logic [1:0][svpwm_pkg::MagW-1:0]       mag_q [N];
  logic [1:0][svpwm_pkg::QuoW-1:0]       quo_q [N];
  svpwm_pkg::div_side_t                  side_q [N];

  logic [1:0][svpwm_pkg::RemW-1:0]       rem_d [N];
  logic [1:0][svpwm_pkg::QuoW-1:0]       quo_d [N];

  // Each stage shifts in one dividend bit and subtracts the divisor when it fits.
  always_comb begin
    logic [svpwm_pkg::RemW-1:0]  rem_src;
    logic [svpwm_pkg::MagW-1:0]  mag_src;
    logic [svpwm_pkg::QuoW-1:0]  quo_src;
    logic [svpwm_pkg::RemW:0]    trial;
    for (int k = 0; k < N; k++) begin
      for (int l = 0; l < 2; l++) begin
        if (k == 0) begin
          // Upper dividend bits are below the smallest divisor, so they seed the remainder.
          mag_src = mag_i[l];
          rem_src = svpwm_pkg::RemW'(mag_i[l] >> N);
          quo_src = '0;
        end else begin
          mag_src = mag_q[k-1][l];
          rem_src = rem_q[k-1][l];
          quo_src = quo_q[k-1][l];
        end
        trial = {rem_src, mag_src[N-1-k]};
        quo_d[k][l] = quo_src;
        if (trial >= {2'b00, den_i}) begin
          rem_d[k][l]        = svpwm_pkg::RemW'(trial - {2'b00, den_i});
          quo_d[k][l][N-1-k] = 1'b1;
        end else begin
          rem_d[k][l] = svpwm_pkg::RemW'(trial);
        end
      end
    end
  end

  // Valid bits advance with the pipeline enable.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[N-2:0], valid_i};
    end
  end

  // Payload stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < N; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
        if (k == 0) begin
          mag_q[k]  <= mag_i;
          side_q[k] <= side_i;
        end else begin
          mag_q[k]  <= mag_q[k-1];
          side_q[k] <= side_q[k-1];
        end
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign quo_o   = quo_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

[design/svpwm_dq_duty_generator_core.sv]
// Top level of the space vector PWM duty generator with inverse Park rotation.
//
//   Channel   Direction  Handshake                      Payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  vd_ref, vq_ref, cos_angle, sin_angle
//   m_axis    out        m_axis_tvalid / m_axis_tready  compares, duties, sector
//   cfg       in         cfg_valid_i / cfg_ready_o      register index and write data
//
// An item passes through five front stages, 35 divider stages (one quotient bit each, set
// by the dwell time division) and five back stages. One item is accepted per cycle unless
// a result waits at the output. The whole pipeline holds while a result waits at the
// output, so nothing is lost or repeated. Reset clears the valid bits and loads the
// register defaults; configuration writes are always ready.
module svpwm_dq_duty_generator_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input items: vd_ref [15:0], vq_ref [31:16], cos_angle [47:32], sin_angle [63:48].
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [63:0]                        s_axis_tdata,
  // Result items: compare_u [16:0], compare_v [33:17], compare_w [50:34],
  // duty_u [68:51], duty_v [86:69], duty_w [104:87], sector [107:105], zeros above.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [111:0]                       m_axis_tdata,
  // Configuration writes.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [svpwm_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [svpwm_pkg::CfgW-1:0]         cfg_data_i
);

  // Configuration registers; the bus voltage is kept as the divisor 866 * max(dc, 1).
  logic [svpwm_pkg::DenW-1:0] den_q;
  logic [svpwm_pkg::CfgW-1:0] period_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      den_q    <= svpwm_pkg::DenW'(svpwm_pkg::DcBusRst) * svpwm_pkg::DenCos30;
      period_q <= svpwm_pkg::PeriodRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == svpwm_pkg::CfgDcBus) begin
        den_q <= svpwm_pkg::DenW'((cfg_data_i == '0) ? svpwm_pkg::CfgW'(1) : cfg_data_i)
                 * svpwm_pkg::DenCos30;
      end else if (cfg_index_i == svpwm_pkg::CfgPeriod) begin
        period_q <= cfg_data_i;
      end
    end
  end

  // Global pipeline enable: move whenever the output register is free or being taken.
  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q;

  assign en            = !v10_q || m_axis_tready;
  assign s_axis_tready = en;

  logic div_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q} <= '0;
    end else if (en) begin
      v1_q  <= s_axis_tvalid;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      v5_q  <= v4_q;
      v6_q  <= div_valid;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= v9_q;
    end
  end

  // Stage 1: the four rotation products.
  logic signed [svpwm_pkg::InW-1:0]   vd, vq, cs, sn;
  logic signed [svpwm_pkg::ProdW-1:0] pa_q, pb_q, pc_q, pd_q;

  assign vd = s_axis_tdata[15:0];
  assign vq = s_axis_tdata[31:16];
  assign cs = s_axis_tdata[47:32];
  assign sn = s_axis_tdata[63:48];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q <= vd * cs;
      pb_q <= vq * sn;
      pc_q <= vd * sn;
      pd_q <= vq * cs;
    end
  end

  // Stage 2: stator frame components X and Y.
  logic signed [svpwm_pkg::XyW-1:0] x_q, y_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q <= svpwm_pkg::XyW'(pa_q) - svpwm_pkg::XyW'(pb_q);
      y_q <= svpwm_pkg::XyW'(pc_q) + svpwm_pkg::XyW'(pd_q);
    end
  end

  // Stage 3: components scaled by the reference vector coefficients.
  logic signed [svpwm_pkg::CrsW-1:0] xe, ye;
  logic signed [svpwm_pkg::CrsW-1:0] a_q, b_q, c_q;

  assign xe = svpwm_pkg::CrsW'(x_q);
  assign ye = svpwm_pkg::CrsW'(y_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= xe * svpwm_pkg::Cos30Milli;
      b_q <= ye * svpwm_pkg::HalfMilli;
      c_q <= ye * svpwm_pkg::OneMilli;
    end
  end

  // Stage 4: the sums that all cross products are built from.
  logic signed [svpwm_pkg::CrsW-1:0] sum_q, dif_q, c4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q <= a_q + b_q;
      dif_q <= a_q - b_q;
      c4_q  <= c_q;
    end
  end

  // Stage 5: sector choice and the two doubled cross products as sign and magnitude.
  logic [svpwm_pkg::SecW-1:0]          sec5;
  logic signed [svpwm_pkg::CrsW-1:0]   n1, n2;
  logic signed [svpwm_pkg::CrsW:0]     n1x, n2x;
  logic [1:0][svpwm_pkg::MagW-1:0]     mag5_q;
  svpwm_pkg::div_side_t                side5_q;

  always_comb begin
    if (!c4_q[svpwm_pkg::CrsW-1]) begin
      if (!dif_q[svpwm_pkg::CrsW-1]) begin
        sec5 = svpwm_pkg::Sector0;
      end else if (!sum_q[svpwm_pkg::CrsW-1]) begin
        sec5 = svpwm_pkg::Sector1;
      end else begin
        sec5 = svpwm_pkg::Sector2;
      end
    end else begin
      if (dif_q[svpwm_pkg::CrsW-1] || dif_q == '0) begin
        sec5 = svpwm_pkg::Sector3;
      end else if (sum_q[svpwm_pkg::CrsW-1] || sum_q == '0) begin
        sec5 = svpwm_pkg::Sector4;
      end else begin
        sec5 = svpwm_pkg::Sector5;
      end
    end
  end

  always_comb begin
    unique case (sec5)
      svpwm_pkg::Sector0: begin n1 = dif_q;  n2 = c4_q;   end
      svpwm_pkg::Sector1: begin n1 = sum_q;  n2 = -dif_q; end
      svpwm_pkg::Sector2: begin n1 = c4_q;   n2 = -sum_q; end
      svpwm_pkg::Sector3: begin n1 = -dif_q; n2 = -c4_q;  end
      svpwm_pkg::Sector4: begin n1 = -sum_q; n2 = dif_q;  end
      default:            begin n1 = -c4_q;  n2 = sum_q;  end
    endcase
    n1x = {n1, 1'b0};
    n2x = {n2, 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag5_q[0]      <= svpwm_pkg::MagW'(n1x[svpwm_pkg::CrsW] ? -n1x : n1x);
      mag5_q[1]      <= svpwm_pkg::MagW'(n2x[svpwm_pkg::CrsW] ? -n2x : n2x);
      side5_q.sector <= sec5;
      side5_q.neg1   <= n1x[svpwm_pkg::CrsW];
      side5_q.neg2   <= n2x[svpwm_pkg::CrsW];
    end
  end

  // Dwell time division by 866 times the bus voltage.
  logic [1:0][svpwm_pkg::QuoW-1:0] quo;
  svpwm_pkg::div_side_t            div_side;

  svpwm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v5_q),
    .mag_i   (mag5_q),
    .side_i  (side5_q),
    .den_i   (den_q),
    .valid_o (div_valid),
    .quo_o   (quo),
    .side_o  (div_side)
  );

  // Stage 6: signed dwell times, truncated toward zero.
  logic signed [svpwm_pkg::DW-1:0] q1, q2;
  logic signed [svpwm_pkg::DW-1:0] t1_q, t2_q;
  logic [svpwm_pkg::SecW-1:0]      sec6_q;

  assign q1 = svpwm_pkg::DW'(quo[0]);
  assign q2 = svpwm_pkg::DW'(quo[1]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_q   <= div_side.neg1 ? -q1 : q1;
      t2_q   <= div_side.neg2 ? -q2 : q2;
      sec6_q <= div_side.sector;
    end
  end

  // Stage 7: zero-vector share, floor of half the remaining time.
  logic signed [svpwm_pkg::DW-1:0] rest;
  logic signed [svpwm_pkg::DW-1:0] z7_q, t1_7_q, t2_7_q;
  logic [svpwm_pkg::SecW-1:0]      sec7_q;

  assign rest = svpwm_pkg::OneQ16 - t1_q - t2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      z7_q   <= rest >>> 1;
      t1_7_q <= t1_q;
      t2_7_q <= t2_q;
      sec7_q <= sec6_q;
    end
  end

  // Stage 8: phase duties in the sector's order.
  logic signed [svpwm_pkg::DW-1:0] du, dv, dw;
  logic signed [svpwm_pkg::DW-1:0] raw8_q [3];
  logic [svpwm_pkg::SecW-1:0]      sec8_q;

  always_comb begin
    unique case (sec7_q)
      svpwm_pkg::Sector0: begin dw = z7_q; dv = dw + t2_7_q; du = dv + t1_7_q; end
      svpwm_pkg::Sector1: begin dw = z7_q; du = dw + t1_7_q; dv = du + t2_7_q; end
      svpwm_pkg::Sector2: begin du = z7_q; dw = du + t2_7_q; dv = dw + t1_7_q; end
      svpwm_pkg::Sector3: begin du = z7_q; dv = du + t1_7_q; dw = dv + t2_7_q; end
      svpwm_pkg::Sector4: begin dv = z7_q; du = dv + t2_7_q; dw = du + t1_7_q; end
      default:            begin dv = z7_q; dw = dv + t1_7_q; du = dw + t2_7_q; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      raw8_q[0] <= du;
      raw8_q[1] <= dv;
      raw8_q[2] <= dw;
      sec8_q    <= sec7_q;
    end
  end

  // Stage 9: clamp and the span one minus duty.
  logic signed [svpwm_pkg::DutyW-1:0] duty9_q [3];
  logic [svpwm_pkg::DutyW-1:0]        span9_q [3];
  logic [svpwm_pkg::SecW-1:0]         sec9_q;

  always_ff @(posedge clk_i) begin
    logic signed [svpwm_pkg::DutyW-1:0] cl;
    if (en) begin
      for (int p = 0; p < 3; p++) begin
        cl          = svpwm_pkg::clamp_duty(raw8_q[p]);
        duty9_q[p]  <= cl;
        span9_q[p]  <= svpwm_pkg::DutyW'(svpwm_pkg::OneQ16) - cl;
      end
      sec9_q <= sec8_q;
    end
  end

  // Stage 10: timer compare values into the output register.
  localparam int unsigned MulW = svpwm_pkg::CfgW + svpwm_pkg::DutyW;

  logic [svpwm_pkg::CmpW-1:0]         cmp10_q [3];
  logic signed [svpwm_pkg::DutyW-1:0] duty10_q [3];
  logic [svpwm_pkg::SecW-1:0]         sec10_q;

  always_ff @(posedge clk_i) begin
    logic [MulW-1:0] prod;
    if (en) begin
      for (int p = 0; p < 3; p++) begin
        prod         = MulW'(period_q) * MulW'(span9_q[p]);
        cmp10_q[p]   <= prod[16 +: svpwm_pkg::CmpW];
        duty10_q[p]  <= duty9_q[p];
      end
      sec10_q <= sec9_q;
    end
  end

  assign m_axis_tvalid = v10_q;
  assign m_axis_tdata  = {4'b0000, sec10_q,
                          duty10_q[2], duty10_q[1], duty10_q[0],
                          cmp10_q[2], cmp10_q[1], cmp10_q[0]};

endmodule
